### rtl/core/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolation block.
// No dependencies; every other file of the block except pli_ram imports this package.
package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 7;
    localparam int ENTRY_W     = 6;
    localparam int STAT_W      = 2;

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Divider: 64-bit dividend, 32-bit divisor, 33 quotient bits.
    localparam int DVD_W       = 64;
    localparam int DVS_W       = 32;
    localparam int QUO_W       = 33;
    localparam int DSTEP_W     = $clog2(QUO_W);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSIDE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FIRST  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LAST   = 2'd2;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        K_LOAD,
        K_QUERY,
        K_SKIP
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [ENTRY_W-1:0]        idx;
        logic signed [DATA_W-1:0]  px;
        logic signed [DATA_W-1:0]  py;
        logic signed [DATA_W-1:0]  qx;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } bp_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

### rtl/core/pli_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the breakpoint table.
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/pli_front.sv
// Front end: accepts input items, classifies them and holds them in a short queue.
// Depends on pli_pkg.
module pli_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [pli_pkg::ENTRY_W-1:0]   entry_index,
    input  logic signed [pli_pkg::DATA_W-1:0] point_x,
    input  logic signed [pli_pkg::DATA_W-1:0] point_y,
    input  logic signed [pli_pkg::DATA_W-1:0] query_x,
    output logic                          head_valid,
    output pli_pkg::item_t                head,
    input  logic                          pop
);
    import pli_pkg::*;

    item_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    item_t              cls;
    logic               push;
    logic               do_pop;

    // A load aimed past the table is marked so the back end drops it.
    always_comb
    begin
        cls.idx  = entry_index;
        cls.px   = point_x;
        cls.py   = point_y;
        cls.qx   = query_x;
        if (cmd == CMD_QUERY)
        begin
            cls.kind = K_QUERY;
        end
        else if (32'(entry_index) < TABLE_DEPTH)
        begin
            cls.kind = K_LOAD;
        end
        else
        begin
            cls.kind = K_SKIP;
        end
    end

    assign in_ready   = (cnt_reg != QCNT_W'(QDEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

### rtl/core/pli_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on pli_pkg. Flags overflow when the quotient needs more than QUO_W bits.
module pli_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pli_pkg::DVD_W-1:0]   dividend,
    input  logic [pli_pkg::DVS_W-1:0]   divisor,
    output logic [pli_pkg::QUO_W-1:0]   quotient,
    output pli_pkg::div_stat_t          stat
);
    import pli_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                ovf_reg, ovf_next;
    logic [DSTEP_W-1:0]  cnt_reg, cnt_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      trial;
    logic                ge;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            dvs_next = divisor;
            // The upper part must stay below the divisor for the quotient to fit.
            if ({1'b0, dividend[DVD_W-1:QUO_W]} >= {1'b0, divisor})
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
                rem_next  = DVS_W'(dividend[DVD_W-1:QUO_W]);
                quo_next  = dividend[QUO_W-1:0];
                cnt_next  = DSTEP_W'(QUO_W - 1);
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

### rtl/core/pli_back.sv
// Back end sequencer: table writes, segment search, interpolation and slope.
// Depends on pli_pkg; drives the table RAM and the shared divider.
module pli_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pli_pkg::CNT_W-1:0]         n_pts,
    input  logic                              head_valid,
    input  pli_pkg::item_t                    head,
    output logic                              pop,
    output logic                              ram_we,
    output logic [pli_pkg::IDX_W-1:0]         ram_waddr,
    output pli_pkg::bp_t                      ram_wdata,
    output logic [pli_pkg::IDX_W-1:0]         ram_raddr,
    input  pli_pkg::bp_t                      ram_rdata,
    output logic                              div_start,
    output logic [pli_pkg::DVD_W-1:0]         div_dividend,
    output logic [pli_pkg::DVS_W-1:0]         div_divisor,
    input  logic [pli_pkg::QUO_W-1:0]         div_quo,
    input  pli_pkg::div_stat_t                div_stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pli_pkg::DATA_W-1:0] value_y,
    output logic signed [pli_pkg::DATA_W-1:0] slope,
    output logic [pli_pkg::STAT_W-1:0]        status
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_PREP, S_MUL, S_DIVV_GO, S_DIVV_WAIT,
        S_SLOPE, S_DIVS_GO, S_DIVS_WAIT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next, j_reg, j_next;
    logic rd_v_reg, rd_v_next, found_reg, found_next, need_val_reg, need_val_next;
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next, y0_reg, y0_next, x1_reg, x1_next;
    logic signed [DATA_W-1:0] xp_reg, xp_next, yp_reg, yp_next, xl_reg, xl_next;
    logic signed [DATA_W-1:0] yl_reg, yl_next, prx_reg, prx_next, pry_reg, pry_next;
    logic signed [DATA_W-1:0] sxa_reg, sxa_next, sya_reg, sya_next;
    logic signed [DATA_W-1:0] sxb_reg, sxb_next, syb_reg, syb_next;
    logic [DVS_W-1:0] mdx_reg, mdx_next, mdy_reg, mdy_next, mdq_reg, mdq_next;
    logic ndx_reg, ndx_next, ndy_reg, ndy_next, ndq_reg, ndq_next;
    logic dxz_reg, dxz_next;
    logic [DVD_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] vy_reg, vy_next, sl_reg, sl_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic ov_reg, ov_next;
    logic signed [DATA_W-1:0] ovy_reg, ovy_next, osl_reg, osl_next;
    logic [STAT_W-1:0] ost_reg, ost_next;

    logic signed [DATA_W:0]   dx, dy, dq;
    logic signed [DATA_W+1:0] dv, sum;
    logic clamp_lo, clamp_hi, brk, neg_s;

    assign brk = ((q_reg >= prx_reg) && (q_reg < ram_rdata.x))
              || ((q_reg <= prx_reg) && (q_reg > ram_rdata.x));
    assign clamp_lo = ((x1_reg > x0_reg) && (x0_reg > q_reg))
                   || ((x1_reg < x0_reg) && (x0_reg < q_reg));
    assign clamp_hi = ((xl_reg > xp_reg) && (q_reg > xl_reg))
                   || ((xl_reg < xp_reg) && (q_reg < xl_reg));
    assign dx    = 33'(sxb_reg) - 33'(sxa_reg);
    assign dy    = 33'(syb_reg) - 33'(sya_reg);
    assign dq    = 33'(q_reg) - 33'(sxa_reg);
    assign neg_s = ndy_reg ^ ndx_reg;
    assign dv    = (ndq_reg ^ ndy_reg ^ ndx_reg) ? -$signed({1'b0, div_quo})
                                                : $signed({1'b0, div_quo});
    assign sum   = 34'(sya_reg) + dv;

    assign ram_waddr = IDX_W'(head.idx);
    assign ram_wdata = '{x: head.px, y: head.py};
    assign ram_raddr = k_reg[IDX_W-1:0];
    assign div_dividend = (state_reg == S_DIVS_GO)
                        ? {16'b0, mdy_reg, 16'b0} : prod_reg;
    assign div_divisor  = mdx_reg;

    always_comb
    begin
        state_next = state_reg;  k_next = k_reg;  j_next = j_reg;
        rd_v_next = 1'b0;  found_next = found_reg;  need_val_next = need_val_reg;
        q_next = q_reg;  x0_next = x0_reg;  y0_next = y0_reg;  x1_next = x1_reg;
        xp_next = xp_reg;  yp_next = yp_reg;  xl_next = xl_reg;  yl_next = yl_reg;
        prx_next = prx_reg;  pry_next = pry_reg;
        sxa_next = sxa_reg;  sya_next = sya_reg;  sxb_next = sxb_reg;  syb_next = syb_reg;
        mdx_next = mdx_reg;  mdy_next = mdy_reg;  mdq_next = mdq_reg;
        ndx_next = ndx_reg;  ndy_next = ndy_reg;  ndq_next = ndq_reg;  dxz_next = dxz_reg;
        prod_next = prod_reg;  vy_next = vy_reg;  sl_next = sl_reg;  st_next = st_reg;
        ov_next = ov_reg;  ovy_next = ovy_reg;  osl_next = osl_reg;  ost_next = ost_reg;
        pop = 1'b0;  ram_we = 1'b0;  div_start = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        K_LOAD:  ram_we = 1'b1;
                        K_QUERY:
                        begin
                            q_next     = head.qx;
                            k_next     = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // Reads are issued back to back; data for entry j arrives in the following cycle.
                if (k_reg < n_pts)
                begin
                    rd_v_next = 1'b1;
                    j_next    = k_reg;
                    k_next    = k_reg + 1'b1;
                end
                if (rd_v_reg)
                begin
                    if (j_reg == '0)
                    begin
                        x0_next = ram_rdata.x;
                        y0_next = ram_rdata.y;
                    end
                    if (j_reg == CNT_W'(1))
                    begin
                        x1_next = ram_rdata.x;
                    end
                    if (j_reg == n_pts - CNT_W'(2))
                    begin
                        xp_next = ram_rdata.x;
                        yp_next = ram_rdata.y;
                    end
                    if (j_reg != '0 && !found_reg && brk)
                    begin
                        found_next = 1'b1;
                        sxa_next = prx_reg;      sya_next = pry_reg;
                        sxb_next = ram_rdata.x;  syb_next = ram_rdata.y;
                    end
                    prx_next = ram_rdata.x;
                    pry_next = ram_rdata.y;
                    if (j_reg == n_pts - CNT_W'(1))
                    begin
                        xl_next    = ram_rdata.x;
                        yl_next    = ram_rdata.y;
                        rd_v_next  = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                sl_next = '0;
                need_val_next = 1'b0;
                if (clamp_lo)
                begin
                    vy_next = y0_reg;  st_next = ST_FIRST;  state_next = S_OUT;
                end
                else if (clamp_hi)
                begin
                    vy_next = yl_reg;  st_next = ST_LAST;   state_next = S_OUT;
                end
                else if (found_reg)
                begin
                    need_val_next = 1'b1;  st_next = ST_INSIDE;  state_next = S_PREP;
                end
                else if (q_reg == xl_reg)
                begin
                    // A point on the last breakpoint takes the last segment's slope.
                    vy_next = yl_reg;  st_next = ST_INSIDE;
                    sxa_next = xp_reg;  sya_next = yp_reg;
                    sxb_next = xl_reg;  syb_next = yl_reg;
                    state_next = S_PREP;
                end
                else
                begin
                    vy_next = yl_reg;  st_next = ST_LAST;  state_next = S_OUT;
                end
            end
            S_PREP:
            begin
                ndx_next = dx[DATA_W];  ndy_next = dy[DATA_W];  ndq_next = dq[DATA_W];
                mdx_next = DVS_W'(dx[DATA_W] ? -dx : dx);
                mdy_next = DVS_W'(dy[DATA_W] ? -dy : dy);
                mdq_next = DVS_W'(dq[DATA_W] ? -dq : dq);
                dxz_next = (dx == '0);
                state_next = need_val_reg ? S_MUL : S_SLOPE;
            end
            S_MUL:
            begin
                prod_next  = DVD_W'(mdq_reg) * DVD_W'(mdy_reg);
                state_next = S_DIVV_GO;
            end
            S_DIVV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVV_WAIT;
            end
            S_DIVV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (sum > 34'sd2147483647)
                    begin
                        vy_next = S32_MAX;
                    end
                    else if (sum < -34'sd2147483648)
                    begin
                        vy_next = S32_MIN;
                    end
                    else
                    begin
                        vy_next = DATA_W'(sum);
                    end
                    state_next = S_SLOPE;
                end
            end
            S_SLOPE:
            begin
                if (dxz_reg)
                begin
                    // Zero-width segment: the slope saturates toward the sign of dy, or is zero when dy is zero.
                    if (mdy_reg == '0)
                    begin
                        sl_next = '0;
                    end
                    else
                    begin
                        sl_next = ndy_reg ? S32_MIN : S32_MAX;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIVS_GO;
                end
            end
            S_DIVS_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVS_WAIT;
            end
            S_DIVS_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (neg_s)
                    begin
                        sl_next = (div_stat.ovf || div_quo > 33'h0_8000_0000)
                                ? S32_MIN : DATA_W'(-div_quo);
                    end
                    else
                    begin
                        sl_next = (div_stat.ovf || div_quo > 33'h0_7FFF_FFFF)
                                ? S32_MAX : DATA_W'(div_quo);
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next  = 1'b1;
                    ovy_next = vy_reg;  osl_next = sl_reg;  ost_next = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;  k_reg <= '0;  j_reg <= '0;  rd_v_reg <= 1'b0;
            found_reg <= 1'b0;  need_val_reg <= 1'b0;  q_reg <= '0;
            x0_reg <= '0;  y0_reg <= '0;  x1_reg <= '0;  xp_reg <= '0;  yp_reg <= '0;
            xl_reg <= '0;  yl_reg <= '0;  prx_reg <= '0;  pry_reg <= '0;
            sxa_reg <= '0;  sya_reg <= '0;  sxb_reg <= '0;  syb_reg <= '0;
            mdx_reg <= '0;  mdy_reg <= '0;  mdq_reg <= '0;
            ndx_reg <= 1'b0;  ndy_reg <= 1'b0;  ndq_reg <= 1'b0;  dxz_reg <= 1'b0;
            prod_reg <= '0;  vy_reg <= '0;  sl_reg <= '0;  st_reg <= ST_INSIDE;
            ov_reg <= 1'b0;  ovy_reg <= '0;  osl_reg <= '0;  ost_reg <= ST_INSIDE;
        end
        else
        begin
            state_reg <= state_next;  k_reg <= k_next;  j_reg <= j_next;
            rd_v_reg <= rd_v_next;  found_reg <= found_next;
            need_val_reg <= need_val_next;  q_reg <= q_next;
            x0_reg <= x0_next;  y0_reg <= y0_next;  x1_reg <= x1_next;
            xp_reg <= xp_next;  yp_reg <= yp_next;  xl_reg <= xl_next;  yl_reg <= yl_next;
            prx_reg <= prx_next;  pry_reg <= pry_next;
            sxa_reg <= sxa_next;  sya_reg <= sya_next;  sxb_reg <= sxb_next;
            syb_reg <= syb_next;
            mdx_reg <= mdx_next;  mdy_reg <= mdy_next;  mdq_reg <= mdq_next;
            ndx_reg <= ndx_next;  ndy_reg <= ndy_next;  ndq_reg <= ndq_next;
            dxz_reg <= dxz_next;
            prod_reg <= prod_next;  vy_reg <= vy_next;  sl_reg <= sl_next;
            st_reg <= st_next;
            ov_reg <= ov_next;  ovy_reg <= ovy_next;  osl_reg <= osl_next;
            ost_reg <= ost_next;
        end
    end

    assign out_valid = ov_reg;
    assign value_y   = ovy_reg;
    assign slope     = osl_reg;
    assign status    = ost_reg;

endmodule

### rtl/core/piecewise_linear_interp_top.sv
// Piecewise linear interpolation over a breakpoint table of signed Q16.16 pairs.
//
// Input channel (in_valid/in_ready): cmd 0 loads entry_index with (point_x, point_y)
// and gives no result; cmd 1 queries at query_x and gives one result item
// (value_y, slope, status) on the output channel (out_valid/out_ready).
// cfg_we/cfg_wdata set the number of breakpoints in use (reset value 2).
//
// Items pass through a two-entry queue into a sequencer that handles one item
// at a time. A load writes the table straight from the idle state. A query scans
// all n breakpoints, with n = points in use, through the table RAM's single read
// port; a clamped query then goes straight to the output, and a bracketed query
// adds a 32x32 multiply and two passes of the 33-step divider.
// One item follows another; the queue keeps the input taking items meanwhile.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits to hand over the next one; the queue fills, then in_ready falls.
// Reset empties the queue and the output register; table contents are
// undefined until loaded.
// Depends on pli_pkg, pli_front, pli_back, pli_div and pli_ram.
module piecewise_linear_interp_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [pli_pkg::ENTRY_W-1:0]       entry_index,
    input  logic signed [pli_pkg::DATA_W-1:0] point_x,
    input  logic signed [pli_pkg::DATA_W-1:0] point_y,
    input  logic signed [pli_pkg::DATA_W-1:0] query_x,
    input  logic                              cfg_we,
    input  logic [pli_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pli_pkg::DATA_W-1:0] value_y,
    output logic signed [pli_pkg::DATA_W-1:0] slope,
    output logic [pli_pkg::STAT_W-1:0]        status
);
    import pli_pkg::*;

    logic [CFG_W-1:0]  npts_reg;
    logic [CNT_W-1:0]  n_eff;
    logic              head_valid, pop;
    item_t             head;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    bp_t               ram_wdata, ram_rdata;
    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [QUO_W-1:0]  div_quo;
    div_stat_t         div_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npts_reg <= CFG_W'(2);
        end
        else if (cfg_we)
        begin
            npts_reg <= cfg_wdata;
        end
    end

    // Counts below two act as two, above the table depth as the depth.
    always_comb
    begin
        if (npts_reg < CFG_W'(2))
        begin
            n_eff = CNT_W'(2);
        end
        else if (32'(npts_reg) > TABLE_DEPTH)
        begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CNT_W'(npts_reg);
        end
    end

    pli_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .entry_index (entry_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    pli_ram #(
        .WIDTH ($bits(bp_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    pli_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_pts        (n_eff),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quo      (div_quo),
        .div_stat     (div_stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value_y      (value_y),
        .slope        (slope),
        .status       (status)
    );

endmodule

### rtl/core/pli_checker.sv
// Port-level checks for the interpolation block, bound to the top level.
// Depends on pli_pkg and piecewise_linear_interp_top.
module pli_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [pli_pkg::DATA_W-1:0] value_y,
    input  logic signed [pli_pkg::DATA_W-1:0] slope,
    input  logic [pli_pkg::STAT_W-1:0]        status
);
    import pli_pkg::*;

    // A stalled result keeps its value until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_y)
                                   && $stable(slope) && $stable(status))
        else $error("result changed while stalled");

    // Clamped results always carry a zero slope.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FIRST || status == ST_LAST) |-> slope == '0)
        else $error("clamped result with nonzero slope");

    // Only the three defined status codes ever leave the block.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_INSIDE || status == ST_FIRST || status == ST_LAST))
        else $error("result with an undefined status code");

    // Handshake signals are never unknown once out of reset.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid, out_ready}))
        else $error("handshake signal is unknown");

endmodule

bind piecewise_linear_interp_top pli_checker u_pli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_y   (value_y),
    .slope     (slope),
    .status    (status)
);
